// File: sv/sata_dma_command_builder_assert.svh
// Assertion macros used by the checker file of this block.
`ifndef SATA_DMA_COMMAND_BUILDER_ASSERT_SVH
`define SATA_DMA_COMMAND_BUILDER_ASSERT_SVH

// Concurrent check that is switched off while reset is asserted.
`define SDCB_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("sdcb assertion failed");

// Concurrent check that also holds across reset.
`define SDCB_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("sdcb assertion failed");

`endif

// File: sv/sdcb_pkg.sv
package sdcb_pkg;

    localparam logic [1:0] KIND_ENTRY    = 2'd0;
    localparam logic [1:0] KIND_CMD      = 2'd1;
    localparam logic [1:0] KIND_NO_SLOT  = 2'd2;
    localparam logic [1:0] KIND_BAD_CNT  = 2'd3;

    localparam logic [7:0] ATA_READ_DMA_EXT  = 8'h25;
    localparam logic [7:0] ATA_WRITE_DMA_EXT = 8'h35;

    localparam logic [63:0] ENTRY_BYTES     = 64'h2000;
    localparam logic [12:0] FULL_ENTRY_M1   = 13'h1FFF;
    localparam int          SECTOR_SHIFT    = 4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ENTRY,
        ST_CMD
    } state_t;

    typedef struct packed {
        logic capture;
        logic load_entry;
        logic load_cmd;
        logic load_err;
    } dp_cmd_t;

    typedef struct packed {
        logic err;
        logic last_entry;
        logic out_free;
    } dp_status_t;

endpackage

// File: sv/sata_dma_command_builder.sv
// Channel  Direction  Handshake          Payload
// s_       in         s_valid/s_ready    op, lba, sector_count, buffer_addr, slots_busy
// m_       out        m_valid/m_ready    kind, slot, entry_addr, entry_bytes_m1,
//                                        fis_command, cmd_lba, cmd_count, write_flag,
//                                        entry_total, last
//
// A good request is taken in, then gives one beat per scatter-gather entry
// (n = ceil(sector_count / 16)) and one for the command, all through the single
// output register. A rejected request gives a single error beat.
// s_ready is high only while the sequencer is idle; the next beat may be taken
// while the command beat still waits in the output register.
// Reset (synchronous, active low) clears the sequencer and the output valid.
// A stall on m_ready holds the output register, and the sequencer while it has a beat to give.
module sata_dma_command_builder #(
    parameter int MAX_ENTRIES = 8,
    parameter int NUM_SLOTS   = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [47:0] s_lba,
    input  logic [15:0] s_sector_count,
    input  logic [63:0] s_buffer_addr,
    input  logic [31:0] s_slots_busy,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [4:0]  m_slot,
    output logic [63:0] m_entry_addr,
    output logic [12:0] m_entry_bytes_m1,
    output logic [7:0]  m_fis_command,
    output logic [47:0] m_cmd_lba,
    output logic [15:0] m_cmd_count,
    output logic        m_write_flag,
    output logic [3:0]  m_entry_total,
    output logic        m_last
);

    sdcb_pkg::dp_cmd_t    dp_cmd;
    sdcb_pkg::dp_status_t dp_status;

    sdcb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (dp_status),
        .cmd     (dp_cmd)
    );

    sdcb_dp #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .NUM_SLOTS   (NUM_SLOTS)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (dp_cmd),
        .status           (dp_status),
        .s_op             (s_op),
        .s_lba            (s_lba),
        .s_sector_count   (s_sector_count),
        .s_buffer_addr    (s_buffer_addr),
        .s_slots_busy     (s_slots_busy),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_kind           (m_kind),
        .m_slot           (m_slot),
        .m_entry_addr     (m_entry_addr),
        .m_entry_bytes_m1 (m_entry_bytes_m1),
        .m_fis_command    (m_fis_command),
        .m_cmd_lba        (m_cmd_lba),
        .m_cmd_count      (m_cmd_count),
        .m_write_flag     (m_write_flag),
        .m_entry_total    (m_entry_total),
        .m_last           (m_last)
    );

endmodule

// File: sv/sdcb_ctrl.sv
module sdcb_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  sdcb_pkg::dp_status_t status,
    output sdcb_pkg::dp_cmd_t   cmd
);

    sdcb_pkg::state_t state_reg;
    sdcb_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sdcb_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            sdcb_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = sdcb_pkg::ST_ENTRY;
                end
            end
            sdcb_pkg::ST_ENTRY: begin
                if (status.out_free) begin
                    if (status.err) begin
                        cmd.load_err = 1'b1;
                        state_next   = sdcb_pkg::ST_IDLE;
                    end else begin
                        cmd.load_entry = 1'b1;
                        if (status.last_entry) begin
                            state_next = sdcb_pkg::ST_CMD;
                        end
                    end
                end
            end
            sdcb_pkg::ST_CMD: begin
                if (status.out_free) begin
                    cmd.load_cmd = 1'b1;
                    state_next   = sdcb_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sdcb_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: sv/sdcb_dp.sv
module sdcb_dp #(
    parameter int MAX_ENTRIES = 8,
    parameter int NUM_SLOTS   = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  sdcb_pkg::dp_cmd_t    cmd,
    output sdcb_pkg::dp_status_t status,
    input  logic                 s_op,
    input  logic [47:0]          s_lba,
    input  logic [15:0]          s_sector_count,
    input  logic [63:0]          s_buffer_addr,
    input  logic [31:0]          s_slots_busy,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_kind,
    output logic [4:0]           m_slot,
    output logic [63:0]          m_entry_addr,
    output logic [12:0]          m_entry_bytes_m1,
    output logic [7:0]           m_fis_command,
    output logic [47:0]          m_cmd_lba,
    output logic [15:0]          m_cmd_count,
    output logic                 m_write_flag,
    output logic [3:0]           m_entry_total,
    output logic                 m_last
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    // Request registers, loaded when the input beat is taken.
    logic              op_reg;
    logic [47:0]       lba_reg;
    logic [15:0]       count_reg;
    logic [63:0]       addr_reg;
    logic [4:0]        slot_reg;
    logic              err_reg;
    logic [1:0]        err_kind_reg;
    logic [IDX_W-1:0]  n_m1_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [3:0]        total_reg;
    logic [12:0]       tail_m1_reg;

    // Output stage.
    logic              out_valid_reg;
    logic [1:0]        out_kind_reg;
    logic [4:0]        out_slot_reg;
    logic [63:0]       out_addr_reg;
    logic [12:0]       out_bytes_reg;
    logic [7:0]        out_fis_reg;
    logic [47:0]       out_lba_reg;
    logic [15:0]       out_count_reg;
    logic              out_write_reg;
    logic [3:0]        out_total_reg;
    logic              out_last_reg;

    logic              slot_found;
    logic [4:0]        slot_idx;
    logic [12:0]       n_entries;
    logic              count_bad;
    logic              out_free;

    // Lowest clear bit among the implemented slots.
    always_comb begin
        slot_found = 1'b0;
        slot_idx   = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (!s_slots_busy[i]) begin
                slot_found = 1'b1;
                slot_idx   = 5'(i);
            end
        end
    end

    assign n_entries = 13'((17'(s_sector_count) + 17'd15) >> sdcb_pkg::SECTOR_SHIFT);
    assign count_bad = (s_sector_count == 16'd0) || (n_entries > 13'(MAX_ENTRIES));
    assign out_free  = !out_valid_reg || m_ready;

    assign status.err        = err_reg;
    assign status.last_entry = (idx_reg == n_m1_reg);
    assign status.out_free   = out_free;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg       <= s_op;
            lba_reg      <= s_lba;
            count_reg    <= s_sector_count;
            addr_reg     <= s_buffer_addr;
            slot_reg     <= slot_idx;
            err_reg      <= !slot_found || count_bad;
            err_kind_reg <= slot_found ? sdcb_pkg::KIND_BAD_CNT : sdcb_pkg::KIND_NO_SLOT;
            n_m1_reg     <= IDX_W'(n_entries - 13'd1);
            idx_reg      <= '0;
            total_reg    <= n_entries[3:0];
            // The final entry carries the sectors left over after the full ones.
            tail_m1_reg  <= {4'(s_sector_count - 16'd1), 9'h1FF};
        end else if (cmd.load_entry) begin
            addr_reg <= addr_reg + sdcb_pkg::ENTRY_BYTES;
            idx_reg  <= idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_entry || cmd.load_cmd || cmd.load_err) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_entry) begin
            out_kind_reg  <= sdcb_pkg::KIND_ENTRY;
            out_slot_reg  <= slot_reg;
            out_addr_reg  <= addr_reg;
            out_bytes_reg <= (idx_reg == n_m1_reg) ? tail_m1_reg : sdcb_pkg::FULL_ENTRY_M1;
            out_fis_reg   <= '0;
            out_lba_reg   <= '0;
            out_count_reg <= '0;
            out_write_reg <= 1'b0;
            out_total_reg <= '0;
            out_last_reg  <= 1'b0;
        end else if (cmd.load_cmd) begin
            out_kind_reg  <= sdcb_pkg::KIND_CMD;
            out_slot_reg  <= slot_reg;
            out_addr_reg  <= '0;
            out_bytes_reg <= '0;
            out_fis_reg   <= op_reg ? sdcb_pkg::ATA_WRITE_DMA_EXT
                                    : sdcb_pkg::ATA_READ_DMA_EXT;
            out_lba_reg   <= lba_reg;
            out_count_reg <= count_reg;
            out_write_reg <= op_reg;
            out_total_reg <= total_reg;
            out_last_reg  <= 1'b1;
        end else if (cmd.load_err) begin
            out_kind_reg  <= err_kind_reg;
            out_slot_reg  <= '0;
            out_addr_reg  <= '0;
            out_bytes_reg <= '0;
            out_fis_reg   <= '0;
            out_lba_reg   <= '0;
            out_count_reg <= '0;
            out_write_reg <= 1'b0;
            out_total_reg <= '0;
            out_last_reg  <= 1'b1;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_kind           = out_kind_reg;
    assign m_slot           = out_slot_reg;
    assign m_entry_addr     = out_addr_reg;
    assign m_entry_bytes_m1 = out_bytes_reg;
    assign m_fis_command    = out_fis_reg;
    assign m_cmd_lba        = out_lba_reg;
    assign m_cmd_count      = out_count_reg;
    assign m_write_flag     = out_write_reg;
    assign m_entry_total    = out_total_reg;
    assign m_last           = out_last_reg;

endmodule

// File: sv/sdcb_checker.sv
`include "sata_dma_command_builder_assert.svh"

module sdcb_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_kind,
    input logic [7:0]  m_fis_command,
    input logic        m_write_flag,
    input logic        m_last
);

    // Output beats stay put while stalled.
    `SDCB_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_last))

    // Nothing is shown in the cycle after reset.
    `SDCB_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_valid)

    // Entries never close a request; errors and commands always do.
    `SDCB_ASSERT(a_entry_not_last, aclk, aresetn, m_valid && (m_kind == sdcb_pkg::KIND_ENTRY) |-> !m_last)
    `SDCB_ASSERT(a_close_last, aclk, aresetn, m_valid && (m_kind != sdcb_pkg::KIND_ENTRY) |-> m_last)

    // The opcode follows the direction bit on every command beat.
    `SDCB_ASSERT(a_cmd_opcode, aclk, aresetn, m_valid && (m_kind == sdcb_pkg::KIND_CMD) |-> (m_write_flag ? (m_fis_command == sdcb_pkg::ATA_WRITE_DMA_EXT) : (m_fis_command == sdcb_pkg::ATA_READ_DMA_EXT)))

endmodule

bind sata_dma_command_builder sdcb_checker u_sdcb_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_kind        (m_kind),
    .m_fis_command (m_fis_command),
    .m_write_flag  (m_write_flag),
    .m_last        (m_last)
);
